// File: hdl/polyline_nearest_progress_core_defines.svh
// ----------------------------------------------------------------------------
// polyline nearest progress assertion macros
// shared concurrent assertion forms, clocked on clk with synchronous reset
// ----------------------------------------------------------------------------
`ifndef POLYLINE_NEAREST_PROGRESS_CORE_DEFINES_SVH
`define POLYLINE_NEAREST_PROGRESS_CORE_DEFINES_SVH

// condition holds on every clock edge out of reset
`define PNP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define PNP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/pnp_pkg.sv
// ----------------------------------------------------------------------------
// pnp_pkg
// shared types and constants of the polyline nearest progress core
// ----------------------------------------------------------------------------
package pnp_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int ALPHA_FRAC_BITS_DEF = 16;
  localparam logic [15:0] TOL_RESET = 16'd1;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_CHECK, OP_MDXX, OP_MDYY, OP_MUXD, OP_MUYD, OP_DOTS,
    OP_DINIT, OP_DIV, OP_MEX, OP_MEY, OP_MPR, OP_MEXX, OP_MEYY, OP_D2S,
    OP_CMP, OP_UPD
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_DINIT, ST_DIV,
    ST_E1, ST_E2, ST_E3, ST_E4, ST_E5, ST_E6, ST_CMP, ST_UPD
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic in_route;
    logic route_bad;
    logic back;
    logic div_run;
    logic out_busy;
  } dp_status_t;

endpackage

// File: hdl/pnp_ctrl.sv
// ----------------------------------------------------------------------------
// pnp_ctrl
// sequencer that steps the shared multiplier and divider per sample
// ----------------------------------------------------------------------------
module pnp_ctrl import pnp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  dp_status_t sts,
  output dp_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (sts.in_route && !sts.route_bad && !sts.back) state_nxt = ST_M1;
        else state_nxt = ST_UPD;
      end
      ST_M1:    state_nxt = ST_M2;
      ST_M2:    state_nxt = ST_M3;
      ST_M3:    state_nxt = ST_M4;
      ST_M4:    state_nxt = ST_M5;
      ST_M5:    state_nxt = ST_DINIT;
      ST_DINIT: state_nxt = ST_DIV;
      ST_DIV:   if (!sts.div_run) state_nxt = ST_E1;
      ST_E1:    state_nxt = ST_E2;
      ST_E2:    state_nxt = ST_E3;
      ST_E3:    state_nxt = ST_E4;
      ST_E4:    state_nxt = ST_E5;
      ST_E5:    state_nxt = ST_E6;
      ST_E6:    state_nxt = ST_CMP;
      ST_CMP:   state_nxt = ST_UPD;
      ST_UPD:   if (!sts.out_busy) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd.op    = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd.op = OP_LOAD;
      end
      ST_CHECK: cmd.op = OP_CHECK;
      ST_M1:    cmd.op = OP_MDXX;
      ST_M2:    cmd.op = OP_MDYY;
      ST_M3:    cmd.op = OP_MUXD;
      ST_M4:    cmd.op = OP_MUYD;
      ST_M5:    cmd.op = OP_DOTS;
      ST_DINIT: cmd.op = OP_DINIT;
      ST_DIV:   if (sts.div_run) cmd.op = OP_DIV;
      ST_E1:    cmd.op = OP_MEX;
      ST_E2:    cmd.op = OP_MEY;
      ST_E3:    cmd.op = OP_MPR;
      ST_E4:    cmd.op = OP_MEXX;
      ST_E5:    cmd.op = OP_MEYY;
      ST_E6:    cmd.op = OP_D2S;
      ST_CMP:   cmd.op = OP_CMP;
      ST_UPD:   if (!sts.out_busy) cmd.op = OP_UPD;
      default:  cmd.op = OP_NONE;
    endcase
  end

endmodule

// File: hdl/pnp_dp.sv
// ----------------------------------------------------------------------------
// pnp_dp
// segment projection datapath: shared multiplier, restoring divider, best keep
// ----------------------------------------------------------------------------
`include "polyline_nearest_progress_core_defines.svh"

module pnp_dp import pnp_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int ALPHA_FRAC_BITS = ALPHA_FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  dp_cmd_t      cmd,
  output dp_status_t   sts,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  input  logic [159:0] in_tdata,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,
  output logic         out_tuser
);

  localparam int A  = ALPHA_FRAC_BITS;
  localparam int MW = 35;
  localparam int PW = 2 * MW;
  localparam int AW = PW + 2;
  localparam int CW = $clog2(A + 1);
  localparam logic [63:0] EPS2 =
    (64'd1 << (2 * COORD_FRAC_BITS)) / 64'd10000000000;
  localparam logic [A:0] ONE = (A+1)'(1) << A;

  logic signed [31:0] pt_x, pt_y, c_x, c_y, c_p;
  assign pt_x = in_tdata[31:0];
  assign pt_y = in_tdata[63:32];
  assign c_x  = in_tdata[95:64];
  assign c_y  = in_tdata[127:96];
  assign c_p  = in_tdata[159:128];

  logic [15:0]        tol_r;
  logic               in_route_r, route_bad_r, seg_seen_r, last_r, back_r, div_run_r;
  logic signed [31:0] qx_r, qy_r, px_r, py_r, pp_r, cx_r, cy_r, cp_r;
  logic signed [32:0] dx_r, dy_r, ux_r, uy_r, dp_r;
  logic signed [PW-1:0] p_r;
  logic signed [AW-1:0] len2_r, dot_r, d2_r;
  logic [AW-1:0]      rem_r;
  logic [A:0]         alpha_r;
  logic [CW-1:0]      cnt_r;
  logic signed [34:0] ex_r, ey_r;
  logic [63:0]        best_d_r;
  logic signed [31:0] best_p_r, cand_p_r;
  logic               out_valid_r, out_user_r;
  logic [31:0]        out_data_r;

  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [AW-1:0] p_ext;
  logic signed [PW-1:0] p_sh;
  logic signed [31:0]   qx_sel, qy_sel;
  logic [AW-1:0]        rem2;
  logic [63:0]          seg_dist;
  logic signed [MW-1:0] alpha_m;

  assign alpha_m  = MW'({1'b0, alpha_r});
  assign p_ext    = AW'(p_r);
  assign p_sh     = p_r >>> A;
  assign qx_sel   = in_route_r ? qx_r : pt_x;
  assign qy_sel   = in_route_r ? qy_r : pt_y;
  assign rem2     = rem_r << 1;
  assign seg_dist = (|d2_r[AW-1:64]) ? {64{1'b1}} : d2_r[63:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_MDXX: begin mul_a = MW'(dx_r); mul_b = MW'(dx_r); end
      OP_MDYY: begin mul_a = MW'(dy_r); mul_b = MW'(dy_r); end
      OP_MUXD: begin mul_a = MW'(ux_r); mul_b = MW'(dx_r); end
      OP_MUYD: begin mul_a = MW'(uy_r); mul_b = MW'(dy_r); end
      OP_MEX:  begin mul_a = MW'(dx_r); mul_b = alpha_m; end
      OP_MEY:  begin mul_a = MW'(dy_r); mul_b = alpha_m; end
      OP_MPR:  begin mul_a = MW'(dp_r); mul_b = alpha_m; end
      OP_MEXX: begin mul_a = ex_r; mul_b = ex_r; end
      OP_MEYY: begin mul_a = ey_r; mul_b = ey_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    p_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r       <= TOL_RESET;
      in_route_r  <= 1'b0;
      route_bad_r <= 1'b0;
      seg_seen_r  <= 1'b0;
      div_run_r   <= 1'b0;
      out_valid_r <= 1'b0;
      qx_r <= '0; qy_r <= '0; px_r <= '0; py_r <= '0; pp_r <= '0;
      best_d_r    <= {64{1'b1}};
      best_p_r    <= '0;
    end else begin
      if (cfg_we) tol_r <= cfg_wdata;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (cmd.op)
        OP_LOAD: begin
          cx_r <= c_x; cy_r <= c_y; cp_r <= c_p; last_r <= in_tlast;
          dx_r <= 33'(c_x) - 33'(px_r);
          dy_r <= 33'(c_y) - 33'(py_r);
          ux_r <= 33'(qx_sel) - 33'(px_r);
          uy_r <= 33'(qy_sel) - 33'(py_r);
          dp_r <= 33'(c_p) - 33'(pp_r);
          back_r <= (34'(c_p) + 34'(signed'({1'b0, tol_r}))) < 34'(pp_r);
          if (!in_route_r) begin
            qx_r <= pt_x; qy_r <= pt_y;
            best_d_r <= {64{1'b1}};
            best_p_r <= '0;
            route_bad_r <= 1'b0;
            seg_seen_r <= 1'b0;
          end
        end
        OP_CHECK: if (in_route_r && !route_bad_r && back_r) route_bad_r <= 1'b1;
        OP_MDYY:  len2_r <= p_ext;
        OP_MUXD:  len2_r <= len2_r + p_ext;
        OP_MUYD:  dot_r <= p_ext;
        OP_DOTS:  dot_r <= dot_r + p_ext;
        OP_DINIT: begin
          rem_r   <= dot_r;
          cnt_r   <= CW'(A);
          if (len2_r <= AW'(EPS2) || dot_r <= 0) begin
            alpha_r   <= '0;
            div_run_r <= 1'b0;
          end else if (dot_r >= len2_r) begin
            alpha_r   <= ONE;
            div_run_r <= 1'b0;
          end else begin
            alpha_r   <= '0;
            div_run_r <= 1'b1;
          end
        end
        OP_DIV: begin
          if (rem2 >= len2_r) begin
            rem_r <= rem2 - len2_r;
            alpha_r <= {alpha_r[A-1:0], 1'b1};
          end else begin
            rem_r <= rem2;
            alpha_r <= {alpha_r[A-1:0], 1'b0};
          end
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CW'(1)) div_run_r <= 1'b0;
        end
        OP_MEY:  ex_r <= 35'(ux_r) - p_sh[34:0];
        OP_MPR:  ey_r <= 35'(uy_r) - p_sh[34:0];
        OP_MEXX: cand_p_r <= pp_r + p_sh[31:0];
        OP_MEYY: d2_r <= p_ext;
        OP_D2S:  d2_r <= d2_r + p_ext;
        OP_CMP: begin
          if (!seg_seen_r || seg_dist < best_d_r) begin
            best_d_r <= seg_dist;
            best_p_r <= cand_p_r;
          end
          seg_seen_r <= 1'b1;
        end
        OP_UPD: begin
          px_r <= cx_r; py_r <= cy_r; pp_r <= cp_r;
          in_route_r <= !last_r;
          if (last_r) begin
            out_valid_r <= 1'b1;
            if (!in_route_r) begin
              out_data_r <= cp_r;
              out_user_r <= 1'b1;
            end else begin
              out_data_r <= route_bad_r ? 32'd0 : best_p_r;
              out_user_r <= !route_bad_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign sts.in_route  = in_route_r;
  assign sts.route_bad = route_bad_r;
  assign sts.back      = back_r;
  assign sts.div_run   = div_run_r;
  assign sts.out_busy  = out_valid_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `PNP_ASSERT_ALWAYS(a_alpha_bound, alpha_r <= ONE || cmd.op != OP_MEX, "alpha above one")
  `PNP_ASSERT_NEXT(a_seen_after_cmp, cmd.op == OP_CMP, seg_seen_r, "segment not marked")
  `PNP_ASSERT_ALWAYS(a_div_cnt, cmd.op != OP_DIV || cnt_r != '0, "divide past last bit")

endmodule

// File: hdl/polyline_nearest_progress_core.sv
// ----------------------------------------------------------------------------
// polyline_nearest_progress_core
// nearest point progress along a streamed route, Q16.16 fixed point
// ----------------------------------------------------------------------------
// channel | dir | transaction
// in_     | in  | one route sample plus query point, tlast ends the route
// out_    | out | nearest progress, tuser = route valid
// cfg_    | in  | progress tolerance write
//
// a sample without a segment steps from idle through check to update; a
// segment also runs the single shared multiplier and, when alpha needs it,
// the bit-serial divider; a new sample is taken only from idle
// a pending result stalls the end of every following sample
// reset is synchronous, active low, and sets tolerance to 1
// ----------------------------------------------------------------------------
module polyline_nearest_progress_core import pnp_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int ALPHA_FRAC_BITS = ALPHA_FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // point_x, point_y, center_x, center_y, sample_progress
  input  logic [159:0] in_tdata,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // nearest_progress
  output logic [31:0]  out_tdata,
  // valid_res
  output logic         out_tuser
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  pnp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pnp_dp #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
